@@ rtl/core/xxk_pkg.sv @@
// shared constants and types of the xxtea keyed stream descrambler
package xxk_pkg;

  localparam int DATA_W        = 32;
  localparam int KEY_WORDS     = 1024;
  localparam int FULL_WORDS    = 512;
  localparam int SPARSE_STRIDE = 64;
  localparam int XX_ROUNDS     = 6;
  localparam int KEY_AW        = $clog2(KEY_WORDS);
  localparam int ROUND_W       = (XX_ROUNDS > 1) ? $clog2(XX_ROUNDS) : 1;
  localparam int POS_W         = $clog2(FULL_WORDS + SPARSE_STRIDE + 1);
  localparam int CFG_IW        = 3;

  localparam logic [DATA_W-1:0] XX_DELTA = 32'h9e37_79b9;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_KEY_PART_0 = 3'd0;
  localparam logic [CFG_IW-1:0] REG_KEY_PART_1 = 3'd1;
  localparam logic [CFG_IW-1:0] REG_KEY_PART_2 = 3'd2;
  localparam logic [CFG_IW-1:0] REG_KEY_PART_3 = 3'd3;

  typedef logic [3:0][DATA_W-1:0] key_t;

  // one cycle's worth of long-key memory traffic
  typedef struct packed {
    logic              we;
    logic [KEY_AW-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [KEY_AW-1:0] raddr;
  } ram_req_t;

endpackage

@@ rtl/core/xxk_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module xxk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/xxk_expand.sv @@
// long-key expansion engine: xxtea rounds over the key memory, one word a cycle
module xxk_expand import xxk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  key_t              key_part,
  input  logic [DATA_W-1:0] rdata,
  output ram_req_t          req,
  output logic              key_ready
);

  typedef enum logic [2:0] {
    EX_IDLE  = 3'b001,
    EX_PRIME = 3'b010,
    EX_STEP  = 3'b100
  } ex_state_t;

  localparam logic [KEY_AW-1:0]  P_LAST   = KEY_AW'(KEY_WORDS - 1);
  localparam logic [KEY_AW-1:0]  P_PENULT = KEY_AW'(KEY_WORDS - 2);
  localparam logic [ROUND_W-1:0] R_LAST   = ROUND_W'(XX_ROUNDS - 1);

  ex_state_t         st;
  logic [KEY_AW-1:0] p;
  logic [ROUND_W-1:0] round;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] cur;        // old value of entry p
  logic [DATA_W-1:0] z;          // last word written
  logic [DATA_W-1:0] first_new;  // entry 0 as written this round

  logic [DATA_W-1:0] y_eff;
  logic [DATA_W-1:0] mix_val;
  logic [DATA_W-1:0] new_word;
  logic [1:0]        key_sel;
  logic [KEY_AW-1:0] read_addr;

  // the first round treats every unwritten entry as zero instead of reading the table
  always_comb begin
    if (p == P_LAST) begin
      y_eff = first_new;
    end else if (round == '0) begin
      y_eff = '0;
    end else begin
      y_eff = rdata;
    end
    key_sel  = p[1:0] ^ sum[3:2];
    mix_val  = (((z >> 5) ^ (y_eff << 2)) + ((y_eff >> 3) ^ (z << 4))) ^
               ((sum ^ y_eff) + (key_part[key_sel] ^ z));
    new_word = cur + mix_val;
  end

  // read address runs two entries ahead of the write, so entry p+1 is at hand for entry p
  always_comb begin
    if (st == EX_PRIME) begin
      read_addr = KEY_AW'(1);
    end else if (p == P_PENULT) begin
      read_addr = '0;
    end else if (p == P_LAST) begin
      read_addr = KEY_AW'(1);
    end else begin
      read_addr = p + KEY_AW'(2);
    end
    req.we    = (st == EX_STEP);
    req.waddr = p;
    req.wdata = new_word;
    req.re    = (st == EX_PRIME) || (st == EX_STEP);
    req.raddr = read_addr;
  end

  assign key_ready = (st == EX_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= EX_PRIME;
    end else if (restart) begin
      st <= EX_PRIME;
    end else begin
      unique case (st)
        EX_IDLE: begin
          st <= EX_IDLE;
        end
        EX_PRIME: begin
          st <= EX_STEP;
        end
        EX_STEP: begin
          if (p == P_LAST && round == R_LAST) begin
            st <= EX_IDLE;
          end
        end
        default: begin
          st <= EX_PRIME;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == EX_PRIME) begin
      p     <= '0;
      round <= '0;
      sum   <= XX_DELTA;
      cur   <= '0;
      z     <= '0;
    end else if (st == EX_STEP) begin
      cur <= y_eff;
      z   <= new_word;
      if (p == '0) begin
        first_new <= new_word;
      end
      if (p == P_LAST) begin
        p     <= '0;
        round <= round + ROUND_W'(1);
        sum   <= sum + XX_DELTA;
      end else begin
        p <= p + KEY_AW'(1);
      end
    end
  end

  a_prime_to_step: assert property (@(posedge clk) disable iff (rst)
    (st == EX_PRIME && !restart && !rst) |=> (st == EX_STEP && p == '0 && round == '0))
    else $error("expansion did not start at entry zero of round zero");

  a_last_step_done: assert property (@(posedge clk) disable iff (rst)
    (st == EX_STEP && p == P_LAST && round == R_LAST && !restart) |=> key_ready)
    else $error("long key not marked ready after final round");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    restart |=> (st == EX_PRIME && !key_ready))
    else $error("key write did not restart expansion");

endmodule

@@ rtl/core/xxtea_keyed_stream_descrambler.sv @@
// top level of the xxtea keyed stream descrambler
//
// input channel: in_valid / in_stall with data_word, first_word, last_word;
//   a request is taken at a clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with out_word, out_last; one result
//   request for every input request, in order
// configuration: cfg_write, cfg_index, cfg_data; indexes 0..3 load the key
//   parts, any other index is ignored; write only while the block is idle
// after reset and after every key write the long key is rebuilt in the key
//   memory: 6 xxtea rounds of 1024 steps, one step a cycle, plus one cycle
//   to prime the read, 6145 cycles in all; in_stall is high meanwhile
// latency: a word taken at edge n appears on the output after edge n+1
//   (key memory read and read stage at edge n, output register at edge n+1)
// throughput: one word per cycle once the key is ready, set by the single
//   read port of the key memory
// when out_stall is high the result holds in the output register, one more
//   word waits in the read stage, and then in_stall rises
module xxtea_keyed_stream_descrambler import xxk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] data_word,
  input  logic              first_word,
  input  logic              last_word,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_word,
  output logic              out_last
);

  localparam logic [KEY_AW-1:0] KP_LAST  = KEY_AW'(KEY_WORDS - 1);
  localparam logic [POS_W-1:0]  POS_FULL = POS_W'(FULL_WORDS);
  localparam logic [POS_W-1:0]  POS_WRAP = POS_W'(FULL_WORDS + SPARSE_STRIDE);

  // key registers
  key_t key_part;
  logic key_write;

  // expansion engine and key memory
  ram_req_t          build_req;
  ram_req_t          ram_req;
  logic [DATA_W-1:0] rdata;
  logic              key_ready;

  // position tracking
  logic [POS_W-1:0]  pos;
  logic [KEY_AW-1:0] kp;
  logic [POS_W-1:0]  pos_eff;
  logic [KEY_AW-1:0] kp_eff;
  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  pos_next;
  logic [KEY_AW-1:0] kp_next;
  logic              apply;

  // read stage and handshake
  logic              in_accept;
  logic              s1_valid;
  logic              s1_move;
  logic [DATA_W-1:0] s1_data;
  logic              s1_last;
  logic              s1_apply;

  // any key write marks the long key stale
  assign key_write = cfg_write && (cfg_index == REG_KEY_PART_0 ||
                                   cfg_index == REG_KEY_PART_1 ||
                                   cfg_index == REG_KEY_PART_2 ||
                                   cfg_index == REG_KEY_PART_3);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_part <= '0;
    end else if (key_write) begin
      key_part[cfg_index[1:0]] <= cfg_data;
    end
  end

  xxk_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .restart   (key_write),
    .key_part  (key_part),
    .rdata     (rdata),
    .req       (build_req),
    .key_ready (key_ready)
  );

  // the memory belongs to the expansion engine until the key is ready
  always_comb begin
    if (key_ready) begin
      ram_req.we    = 1'b0;
      ram_req.waddr = '0;
      ram_req.wdata = '0;
      ram_req.re    = in_accept;
      ram_req.raddr = kp_eff;
    end else begin
      ram_req = build_req;
    end
  end

  xxk_ram #(
    .WIDTH (DATA_W),
    .DEPTH (KEY_WORDS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  // handshake: read stage moves on when the output register is free
  assign s1_move   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = !key_ready || (s1_valid && !s1_move);
  assign in_accept = in_valid && !in_stall;

  // dense region xors every word, sparse region only the first of each stride
  always_comb begin
    pos_eff = first_word ? '0 : pos;
    kp_eff  = first_word ? '0 : kp;
    apply   = (pos_eff <= POS_FULL);
    pos_inc = pos_eff + POS_W'(1);
    if (last_word) begin
      pos_next = '0;
      kp_next  = '0;
    end else begin
      pos_next = (pos_inc >= POS_WRAP) ? POS_FULL : pos_inc;
      if (apply) begin
        kp_next = (kp_eff == KP_LAST) ? '0 : kp_eff + KEY_AW'(1);
      end else begin
        kp_next = kp_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      kp  <= '0;
    end else if (in_accept) begin
      pos <= pos_next;
      kp  <= kp_next;
    end
  end

  // read stage: key word arrives from memory in the cycle after the request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data  <= data_word;
      s1_last  <= last_word;
      s1_apply <= apply;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_word <= s1_data ^ (s1_apply ? rdata : '0);
      out_last <= s1_last;
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> (s1_valid && $stable(s1_data) && $stable(rdata)))
    else $error("read stage lost its word while the output was stalled");

  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("word left the read stage without reaching the output");

  a_no_take_building: assert property (@(posedge clk) disable iff (rst)
    !key_ready |-> (in_stall && !ram_req.re || ram_req == build_req))
    else $error("stream access to key memory during expansion");

endmodule
